/* design/multi_size_pool_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Multi-size pool allocator assertion macros
// Property wrappers clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MULTI_SIZE_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define MULTI_SIZE_POOL_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define MSPA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mspa assertion failed");

// next-cycle implication
`define MSPA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mspa assertion failed");

`endif

/* design/mspa_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-size pool allocator package
// Word types, status and mode codes, register indexes.
// ----------------------------------------------------------------------------
package mspa_pkg;

  localparam int SIZE_W    = 9;
  localparam int OFF_W     = 10;
  localparam int CFG_W     = 9;
  localparam int IDX_W     = 3;
  localparam int DIV_STEPS = 9;
  localparam int REG_CLASSES = 4;

  localparam logic [CFG_W-1:0] BLOCK_RESET = 9'd256;

  localparam logic [IDX_W-1:0] REG_BLOCK_BYTES = 3'd0;
  localparam logic [IDX_W-1:0] REG_CLASS_A     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CLASS_B     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CLASS_C     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CLASS_D     = 3'd4;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_CLASS = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_RANGE    = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  free_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] slot_offset;
  } out_t;

endpackage

/* design/multi_size_pool_allocator_top.sv */
// ----------------------------------------------------------------------------
// Multi-size pool allocator
// Used map of a pool split into size-class regions; allocate and free.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears the used map, one mark per cycle.
// Each word then holds busy high while the region layout is rebuilt for it by
// one shared 9-step restoring divider, one class at a time. A free walks every
// class and then clears its mark in the used map if the offset is in range; an
// allocate with no matching class walks every class; a matching allocate walks
// the classes up to the matching one, then probes slots in the used-map RAM
// (one read issued per cycle). The result is shown on result for the single
// cycle that done is high and cannot be held off; start is taken in any cycle
// where busy is low, that cycle included.
module multi_size_pool_allocator_top #(
  parameter int MAX_BLOCK_BYTES = 256,
  parameter int NUM_CLASSES     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  mspa_pkg::in_t                 item,
  output logic                          done,
  output mspa_pkg::out_t                result,
  input  logic                          cfg_we,
  input  logic [mspa_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mspa_pkg::CFG_W-1:0]    cfg_data
);

  localparam int POOL_BYTES = NUM_CLASSES * MAX_BLOCK_BYTES;
  localparam int AW  = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam int PW  = $clog2(POOL_BYTES + 1);
  localparam int XW  = (PW > mspa_pkg::OFF_W) ? PW : mspa_pkg::OFF_W;
  localparam int CW  = $clog2(NUM_CLASSES + 1);
  localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW  = mspa_pkg::SIZE_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_CLASS, S_SCAN, S_FREE} state_t;

  state_t          state;
  logic [SW-1:0]   block_bytes;
  logic [SW-1:0]   class_size [2**CIW];

  logic            req_mode;
  logic [SW-1:0]   req_size;
  logic [mspa_pkg::OFF_W-1:0] req_off;
  logic [CW-1:0]   cls;
  logic [SW-1:0]   dvd;
  logic [SW-1:0]   rem;
  logic [3:0]      step;
  logic [PW-1:0]   acc;
  logic [PW-1:0]   scan_pos;
  logic [SW:0]     scan_i;
  logic [SW-1:0]   scan_len;
  logic [SW-1:0]   scan_sz;
  logic            pend_valid;
  logic [PW-1:0]   pend_pos;
  logic [AW-1:0]   clr_addr;

  logic [SW-1:0]   b_eff;
  logic [SW-1:0]   sz;
  logic [SW:0]     rem_sh;
  logic [SW:0]     rem_next;
  logic [SW-1:0]   len;
  logic [PW-1:0]   acc_next;
  logic            last_cls;
  logic            match;
  logic            issue;
  logic            hit;
  logic [XW-1:0]   off_x;
  logic            in_range;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            ram_wdata;
  logic            ram_rdata;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= mspa_pkg::BLOCK_RESET;
      for (int k = 0; k < 2**CIW; k++) begin
        class_size[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mspa_pkg::REG_BLOCK_BYTES) begin
        block_bytes <= cfg_data;
      end
      for (int k = 0; k < NUM_CLASSES && k < mspa_pkg::REG_CLASSES; k++) begin
        if (cfg_index == mspa_pkg::IDX_W'(k + 1)) begin
          class_size[k] <= cfg_data;
        end
      end
    end
  end

  assign b_eff    = (int'(block_bytes) > MAX_BLOCK_BYTES) ? SW'(MAX_BLOCK_BYTES)
                                                          : block_bytes;
  assign sz       = class_size[cls[CIW-1:0]];
  assign rem_sh   = {rem, dvd[SW-1]};
  assign rem_next = (rem_sh >= {1'b0, sz}) ? (rem_sh - {1'b0, sz}) : rem_sh;
  assign len      = (sz == '0) ? '0 : (b_eff - rem);
  assign acc_next = acc + PW'(len);
  assign last_cls = (cls == CW'(NUM_CLASSES - 1));
  assign match    = (req_size != '0) && (sz == req_size);
  assign issue    = (state == S_SCAN) && (scan_i < {1'b0, scan_len});
  assign hit      = pend_valid && !ram_rdata;
  assign off_x    = XW'(req_off);
  assign in_range = (off_x < XW'(acc)) && (off_x < XW'(POOL_BYTES));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_we    = hit;
        ram_waddr = pend_pos[AW-1:0];
        ram_wdata = 1'b1;
      end
      S_FREE: begin
        ram_we    = in_range;
        ram_waddr = off_x[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  mspa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_BYTES)
  ) u_used_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_pos[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(POOL_BYTES - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req_mode <= item.mode;
            req_size <= item.request_size;
            req_off  <= item.free_offset;
            cls      <= '0;
            acc      <= '0;
            dvd      <= b_eff;
            rem      <= '0;
            step     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= rem_next[SW-1:0];
          dvd  <= dvd << 1;
          step <= step + 1'b1;
          if (step == 4'(mspa_pkg::DIV_STEPS - 1)) begin
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          dvd  <= b_eff;
          rem  <= '0;
          step <= '0;
          cls  <= cls + 1'b1;
          if (req_mode == mspa_pkg::MODE_FREE) begin
            acc   <= acc_next;
            state <= last_cls ? S_FREE : S_DIV;
          end else if (match) begin
            scan_pos   <= acc;
            scan_i     <= '0;
            scan_len   <= len;
            scan_sz    <= sz;
            pend_valid <= 1'b0;
            state      <= S_SCAN;
          end else begin
            acc <= acc_next;
            if (last_cls) begin
              result.status      <= mspa_pkg::STATUS_NO_CLASS;
              result.slot_offset <= '0;
              done               <= 1'b1;
              state              <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_SCAN: begin
          pend_valid <= issue;
          pend_pos   <= scan_pos;
          if (issue) begin
            scan_pos <= scan_pos + PW'(scan_sz);
            scan_i   <= scan_i + {1'b0, scan_sz};
          end
          if (hit) begin
            result.status      <= mspa_pkg::STATUS_OK;
            result.slot_offset <= mspa_pkg::OFF_W'(XW'(pend_pos));
            done               <= 1'b1;
            state              <= S_IDLE;
          end else if (!issue) begin
            result.status      <= mspa_pkg::STATUS_FULL;
            result.slot_offset <= '0;
            done               <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_FREE: begin
          result.status      <= in_range ? mspa_pkg::STATUS_OK : mspa_pkg::STATUS_RANGE;
          result.slot_offset <= '0;
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/mspa_ram.sv */
// ----------------------------------------------------------------------------
// Multi-size pool allocator generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mspa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mspa_check.sv */
// ----------------------------------------------------------------------------
// Multi-size pool allocator port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_size_pool_allocator_top_assert.svh"

module mspa_check (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input mspa_pkg::out_t result
);

  // hold busy once a word is taken
  `MSPA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // drop busy when the result word is shown
  `MSPA_ASSERT_IMP(a_done_idle, done, !busy)
  // no result word straight after acceptance
  `MSPA_ASSERT_NXT(a_accept_quiet, start && !busy, !done)
  // results with a status other than OK carry no offset
  `MSPA_ASSERT_IMP(a_fail_zero, done && result.status != mspa_pkg::STATUS_OK,
                   result.slot_offset == '0)

endmodule

bind multi_size_pool_allocator_top mspa_check u_mspa_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
